// File: hw/rtl/rmb_pkg.sv
package rmb_pkg;

  localparam int NumBoxes  = 16;
  localparam int MaxSteps  = 8192;
  localparam int BoxIdxW   = 4;
  localparam int StepCntW  = 14;
  localparam int CoordW    = 25;
  localparam int PosW      = 27;
  localparam int MagW      = 32;
  localparam int KW        = 24;

  localparam logic [2:0] RegCamX   = 3'd0;
  localparam logic [2:0] RegCamY   = 3'd1;
  localparam logic [2:0] RegCamZ   = 3'd2;
  localparam logic [2:0] RegStep   = 3'd3;
  localparam logic [2:0] RegMaxDst = 3'd4;

  localparam logic KindLoad  = 1'b0;
  localparam logic KindTrace = 1'b1;

  typedef struct packed {
    logic               kind;
    logic [3:0]         box_index;
    logic               box_enable;
    logic signed [23:0] center_x;
    logic signed [23:0] center_y;
    logic signed [23:0] center_z;
    logic [22:0]        extent_x;
    logic [22:0]        extent_y;
    logic [22:0]        extent_z;
    logic signed [15:0] tan_h;
    logic signed [15:0] tan_v;
  } in_item_t;

  typedef struct packed {
    logic        hit;
    logic [15:0] depth;
    logic        load_done;
  } out_item_t;

  typedef struct packed {
    logic signed [CoordW-1:0] lo_x;
    logic signed [CoordW-1:0] hi_x;
    logic signed [CoordW-1:0] lo_y;
    logic signed [CoordW-1:0] hi_y;
    logic signed [CoordW-1:0] lo_z;
    logic signed [CoordW-1:0] hi_z;
  } box_t;

  typedef struct packed {
    logic                  vld;
    logic signed [PosW-1:0] px;
    logic signed [PosW-1:0] py;
    logic signed [PosW-1:0] pz;
    logic [KW-1:0]         k;
    logic                  last;
  } probe_t;

endpackage

// File: hw/rtl/rmb_cell.sv
module rmb_cell import rmb_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   wr_i,
  input  logic   en_i,
  input  box_t   box_i,
  input  probe_t probe_i,
  input  logic   hit_i,
  output probe_t probe_o,
  output logic   hit_o
);

  logic valid_q;
  box_t box_q;
  probe_t probe_q;
  logic vld_q;
  logic hit_q, in_box;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (wr_i) begin
      valid_q <= en_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      box_q <= box_i;
    end
  end

  always_comb begin
    in_box = valid_q &&
      probe_i.px >= PosW'(box_q.lo_x) && probe_i.px <= PosW'(box_q.hi_x) &&
      probe_i.py >= PosW'(box_q.lo_y) && probe_i.py <= PosW'(box_q.hi_y) &&
      probe_i.pz >= PosW'(box_q.lo_z) && probe_i.pz <= PosW'(box_q.hi_z);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
      hit_q <= 1'b0;
    end else begin
      vld_q <= probe_i.vld;
      hit_q <= probe_i.vld && (hit_i || in_box);
    end
  end

  always_ff @(posedge clk_i) begin
    probe_q <= probe_i;
  end

  always_comb begin
    probe_o     = probe_q;
    probe_o.vld = vld_q;
  end

  assign hit_o = hit_q;

endmodule

// File: hw/rtl/rmb_div.sv
module rmb_div import rmb_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] num_i,
  input  logic [39:0] den_i,
  output logic        done_o,
  output logic [39:0] quo_o
);

  logic [6:0]  cnt_q;
  logic        run_q;
  logic [63:0] num_q;
  logic [40:0] rem_q;
  logic [39:0] quo_q;
  logic [40:0] trial;

  assign trial = {rem_q[39:0], num_q[63]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      cnt_q  <= '0;
      done_o <= 1'b0;
    end else begin
      done_o <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= 7'd64;
      end else if (run_q) begin
        cnt_q <= cnt_q - 7'd1;
        if (cnt_q == 7'd1) begin
          run_q  <= 1'b0;
          done_o <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= num_i;
      rem_q <= '0;
      quo_q <= '0;
    end else if (run_q) begin
      num_q <= {num_q[62:0], 1'b0};
      if (trial >= {1'b0, den_i}) begin
        rem_q <= trial - {1'b0, den_i};
        quo_q <= {quo_q[38:0], 1'b1};
      end else begin
        rem_q <= trial;
        quo_q <= {quo_q[38:0], 1'b0};
      end
    end
  end

  assign quo_o = quo_q;

endmodule

// File: hw/rtl/ray_march_box_scene_top.sv
// Box-table ray marcher. A load item (kind 0) writes one slot in the StLoad state
// and answers with a registered load_done. A trace item (kind 1) first computes
// the unit direction with a bit-serial square root and three bit-serial
// divisions, then emits one sample point per cycle into a chain of NumBoxes
// cells, one box per cell, and ends with a depth division (only on a hit with a
// nonzero max_distance). A miss marches until MaxSteps samples or the range is
// used up and then drains the chain; a hit stops issuing samples once the first
// hit leaves the chain and adds the depth division.
// Every item answers with exactly one result_valid_o pulse;
// the receiver cannot stall, so result_o must be sampled in that cycle.
module ray_march_box_scene_top import rmb_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start,
  output logic      busy,
  input  in_item_t  item_i,
  output logic      result_valid_o,
  output out_item_t result_o,
  input  logic      cfg_valid_i,
  output logic      cfg_ready_o,
  input  logic [2:0] cfg_index_i,
  input  logic [23:0] cfg_data_i
);

  typedef enum logic [3:0] {
    StIdle, StLoad, StSqrt, StDivX, StDivY, StDivZ, StMarch, StDrain, StDepth, StOut
  } state_e;

  state_e state_q;
  logic signed [23:0] cam_x_q, cam_y_q, cam_z_q;
  logic [15:0] step_q;
  logic [22:0] maxd_q;
  in_item_t it_q;

  // sqrt
  logic [51:0] sq_n_q;
  logic [25:0] sq_r_q;
  logic [26:0] sq_rem_q;
  logic [4:0]  sq_cnt_q;
  logic [29:0] sq_trial;
  logic [15:0] in_atv, in_ath;
  logic [31:0] in_sq;

  logic [MagW-1:0] mx_q, my_q, mz_q;
  logic div_start_q, div_done;
  logic [63:0] div_num;
  logic [39:0] div_den, div_quo;

  logic [StepCntW-1:0] i_q;
  logic [KW-1:0] k_q;
  logic found_q;
  logic [KW-1:0] khit_q;
  probe_t probe_in;
  logic [15:0] dep_q;

  probe_t chain_p [NumBoxes+1];
  logic   chain_h [NumBoxes+1];
  logic   load_wr;
  box_t   load_box;

  logic [15:0] atv, ath;
  logic [55:0] ox, oy, oz;

  assign cfg_ready_o = 1'b1;
  assign busy = (state_q != StIdle);
  assign atv = it_q.tan_v[15] ? 16'(-it_q.tan_v) : 16'(it_q.tan_v);
  assign ath = it_q.tan_h[15] ? 16'(-it_q.tan_h) : 16'(it_q.tan_h);

  // squared direction length of the incoming beat, Q.28
  assign in_atv = item_i.tan_v[15] ? 16'(-item_i.tan_v) : 16'(item_i.tan_v);
  assign in_ath = item_i.tan_h[15] ? 16'(-item_i.tan_h) : 16'(item_i.tan_h);
  assign in_sq  = 32'd268435456 + 32'(in_atv) * 32'(in_atv) + 32'(in_ath) * 32'(in_ath);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cam_x_q <= 24'sd1638400;
      cam_y_q <= '0;
      cam_z_q <= '0;
      step_q  <= 16'd655;
      maxd_q  <= 23'd3276800;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        RegCamX:   cam_x_q <= cfg_data_i;
        RegCamY:   cam_y_q <= cfg_data_i;
        RegCamZ:   cam_z_q <= cfg_data_i;
        RegStep:   step_q  <= cfg_data_i[15:0];
        RegMaxDst: maxd_q  <= cfg_data_i[22:0];
        default: ;
      endcase
    end
  end

  assign sq_trial = {1'b0, sq_rem_q, sq_n_q[51:50]} - {2'b00, sq_r_q, 2'b01};

  rmb_div u_div (
    .clk_i, .rst_ni, .start_i(div_start_q), .num_i(div_num), .den_i(div_den),
    .done_o(div_done), .quo_o(div_quo)
  );

  always_comb begin
    div_den = {14'd0, sq_r_q};
    case (state_q)
      StDivX:  div_num = 64'd1 << 54;
      StDivY:  div_num = {8'd0, atv, 40'd0};
      StDivZ:  div_num = {8'd0, ath, 40'd0};
      StDepth: begin
        div_num = {24'd0, khit_q, 16'd0};
        div_den = {17'd0, maxd_q};
      end
      default: div_num = '0;
    endcase
  end

  assign ox = mx_q * k_q + (56'd1 << 29);
  assign oy = my_q * k_q + (56'd1 << 29);
  assign oz = mz_q * k_q + (56'd1 << 29);

  always_comb begin
    probe_in.vld  = (state_q == StMarch) && !found_q;
    probe_in.px   = PosW'(cam_x_q) - PosW'(ox[55:30]);
    probe_in.py   = it_q.tan_v[15] ? PosW'(cam_y_q) - PosW'(oy[55:30])
                                   : PosW'(cam_y_q) + PosW'(oy[55:30]);
    probe_in.pz   = it_q.tan_h[15] ? PosW'(cam_z_q) - PosW'(oz[55:30])
                                   : PosW'(cam_z_q) + PosW'(oz[55:30]);
    probe_in.k    = k_q;
    probe_in.last = (i_q == StepCntW'(MaxSteps - 1)) || (step_q == 16'd0) ||
                    ({1'b0, k_q} + {9'd0, step_q} > {2'b0, maxd_q});
  end

  assign chain_p[0] = probe_in;
  assign chain_h[0] = 1'b0;
  assign load_wr = (state_q == StLoad);
  assign load_box.lo_x = CoordW'(it_q.center_x) - CoordW'(it_q.extent_x[22:1]);
  assign load_box.hi_x = CoordW'(it_q.center_x) + CoordW'(it_q.extent_x[22:1]);
  assign load_box.lo_y = CoordW'(it_q.center_y) - CoordW'(it_q.extent_y[22:1]);
  assign load_box.hi_y = CoordW'(it_q.center_y) + CoordW'(it_q.extent_y[22:1]);
  assign load_box.lo_z = CoordW'(it_q.center_z) - CoordW'(it_q.extent_z[22:1]);
  assign load_box.hi_z = CoordW'(it_q.center_z) + CoordW'(it_q.extent_z[22:1]);

  for (genvar g = 0; g < NumBoxes; g++) begin : g_cell
    rmb_cell u_cell (
      .clk_i, .rst_ni,
      .wr_i(load_wr && it_q.box_index == BoxIdxW'(g)),
      .en_i(it_q.box_enable), .box_i(load_box),
      .probe_i(chain_p[g]), .hit_i(chain_h[g]),
      .probe_o(chain_p[g+1]), .hit_o(chain_h[g+1])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= StIdle;
      div_start_q    <= 1'b0;
      result_valid_o <= 1'b0;
      found_q        <= 1'b0;
      sq_cnt_q       <= '0;
      i_q            <= '0;
    end else begin
      div_start_q    <= 1'b0;
      result_valid_o <= 1'b0;
      case (state_q)
        StIdle: if (start) begin
          it_q  <= item_i;
          state_q <= (item_i.kind == KindLoad) ? StLoad : StSqrt;
          sq_n_q <= {in_sq, 20'd0};
          sq_r_q <= '0;
          sq_rem_q <= '0;
          sq_cnt_q <= 5'd25;
        end
        StLoad: begin
          result_o       <= '{hit: 1'b0, depth: 16'd0, load_done: 1'b1};
          result_valid_o <= 1'b1;
          state_q        <= StIdle;
        end
        StSqrt: begin
          sq_n_q <= {sq_n_q[49:0], 2'b00};
          if (!sq_trial[29]) begin
            sq_rem_q <= sq_trial[26:0];
            sq_r_q   <= {sq_r_q[24:0], 1'b1};
          end else begin
            sq_rem_q <= {sq_rem_q[24:0], sq_n_q[51:50]};
            sq_r_q   <= {sq_r_q[24:0], 1'b0};
          end
          if (sq_cnt_q == 5'd0) begin
            state_q     <= StDivX;
            div_start_q <= 1'b1;
          end else begin
            sq_cnt_q <= sq_cnt_q - 5'd1;
          end
        end
        StDivX: if (div_done) begin
          mx_q <= div_quo[MagW-1:0];
          state_q <= StDivY;
          div_start_q <= 1'b1;
        end
        StDivY: if (div_done) begin
          my_q <= div_quo[MagW-1:0];
          state_q <= StDivZ;
          div_start_q <= 1'b1;
        end
        StDivZ: if (div_done) begin
          mz_q <= div_quo[MagW-1:0];
          state_q <= StMarch;
          i_q <= '0;
          k_q <= '0;
          found_q <= 1'b0;
        end
        StMarch: begin
          if (chain_p[NumBoxes].vld && chain_h[NumBoxes] && !found_q) begin
            found_q <= 1'b1;
            khit_q  <= chain_p[NumBoxes].k;
          end
          if (probe_in.vld) begin
            i_q <= i_q + StepCntW'(1);
            k_q <= k_q + KW'(step_q);
            if (probe_in.last) begin
              state_q  <= StDrain;
              sq_cnt_q <= 5'(NumBoxes);
            end
          end
          if (found_q || (chain_p[NumBoxes].vld && chain_h[NumBoxes])) begin
            state_q  <= StDrain;
            sq_cnt_q <= 5'(NumBoxes);
          end
        end
        StDrain: begin
          if (chain_p[NumBoxes].vld && chain_h[NumBoxes] && !found_q) begin
            found_q <= 1'b1;
            khit_q  <= chain_p[NumBoxes].k;
          end
          if (sq_cnt_q == 5'd0) begin
            // zero range only samples the camera point, depth stays 0
            if (found_q && maxd_q != 23'd0) begin
              state_q <= StDepth;
              div_start_q <= 1'b1;
            end else begin
              dep_q <= '0;
              state_q <= StOut;
            end
          end else begin
            sq_cnt_q <= sq_cnt_q - 5'd1;
          end
        end
        StDepth: if (div_done) begin
          dep_q <= (div_quo > 40'd65535) ? 16'hFFFF : div_quo[15:0];
          state_q <= StOut;
        end
        StOut: begin
          result_o       <= '{hit: found_q, depth: found_q ? dep_q : 16'd0,
                              load_done: 1'b0};
          result_valid_o <= 1'b1;
          state_q        <= StIdle;
        end
        default: state_q <= StIdle;
      endcase
    end
  end

endmodule

// File: sim/ray_march_box_scene_top_tb.sv
`timescale 1ns / 1ps

module ray_march_box_scene_top_tb;
  import rmb_pkg::*;

  localparam int U = 65536;
  localparam int WatchdogLimit = 60000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  in_item_t    item_i = '0;
  logic        result_valid_o;
  out_item_t   result_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i = RegCamX;
  logic [23:0] cfg_data_i = '0;

  ray_march_box_scene_top dut (
    .clk_i, .rst_ni, .start, .busy, .item_i, .result_valid_o, .result_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  always #5 clk_i = ~clk_i;

  // scene and camera as seen by the predictor
  longint          cam_x = 1638400, cam_y = 0, cam_z = 0;
  longint unsigned step_len = 655, max_dist = 3276800;
  bit              box_on [NumBoxes];
  longint          box_lo [NumBoxes][3];
  longint          box_hi [NumBoxes][3];

  in_item_t  item_q [$];
  out_item_t depth_q [$];
  int        send_idle = 33;
  int        errors = 0, n_loads = 0, n_traces = 0, n_hits = 0, n_results = 0;
  int        quiet_cycles = 0;

  function automatic longint ray_offset(longint unsigned mag, bit neg, longint unsigned k);
    longint o;
    o = longint'((mag * k + (64'd1 << 29)) >> 30);
    return neg ? -o : o;
  endfunction

  function automatic out_item_t march(in_item_t it);
    out_item_t       r;
    longint          tv, th, p [3];
    longint unsigned atv, ath, s, n, root, bitv, mx, my, mz, k, d;
    int              b, a;
    bit              found;
    r = '0;
    if (it.kind == KindLoad) begin
      box_on[it.box_index] = it.box_enable;
      box_lo[it.box_index][0] = longint'(it.center_x) - longint'(it.extent_x >> 1);
      box_hi[it.box_index][0] = longint'(it.center_x) + longint'(it.extent_x >> 1);
      box_lo[it.box_index][1] = longint'(it.center_y) - longint'(it.extent_y >> 1);
      box_hi[it.box_index][1] = longint'(it.center_y) + longint'(it.extent_y >> 1);
      box_lo[it.box_index][2] = longint'(it.center_z) - longint'(it.extent_z >> 1);
      box_hi[it.box_index][2] = longint'(it.center_z) + longint'(it.extent_z >> 1);
      r.load_done = 1'b1;
      return r;
    end
    tv = it.tan_v;
    th = it.tan_h;
    atv = (tv < 0) ? -tv : tv;
    ath = (th < 0) ? -th : th;
    s = (64'd1 << 28) + atv * atv + ath * ath;
    // integer square root of s << 20, digit by digit
    n = s << 20;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= root + bitv) begin
        n -= root + bitv;
        root = (root >> 1) + bitv;
      end else begin
        root >>= 1;
      end
      bitv >>= 2;
    end
    mx = (64'd1 << 54) / root;
    my = (atv << 40) / root;
    mz = (ath << 40) / root;
    for (longint unsigned i = 0; i < MaxSteps; i++) begin
      k = i * step_len;
      if (k > max_dist) break;
      p[0] = cam_x + ray_offset(mx, 1'b1, k);
      p[1] = cam_y + ray_offset(my, tv < 0, k);
      p[2] = cam_z + ray_offset(mz, th < 0, k);
      found = 1'b0;
      for (b = 0; b < NumBoxes; b++) begin
        if (box_on[b]) begin
          found = 1'b1;
          for (a = 0; a < 3; a++)
            if (p[a] < box_lo[b][a] || p[a] > box_hi[b][a]) found = 1'b0;
          if (found) break;
        end
      end
      if (found) begin
        d = 0;
        if (max_dist != 0) begin
          d = (k << 16) / max_dist;
          if (d > 65535) d = 65535;
        end
        r.hit = 1'b1;
        r.depth = d[15:0];
        break;
      end
      if (step_len == 0) break;
    end
    return r;
  endfunction

  function automatic in_item_t box_beat(int idx, bit en, int cx, int cy, int cz, int ex, int ey,
                                        int ez);
    in_item_t it;
    it = '0;
    it.kind = KindLoad;
    it.box_index = 4'(idx);
    it.box_enable = en;
    it.center_x = 24'(cx); it.center_y = 24'(cy); it.center_z = 24'(cz);
    it.extent_x = 23'(ex); it.extent_y = 23'(ey); it.extent_z = 23'(ez);
    return it;
  endfunction

  function automatic in_item_t ray_beat(int th, int tv);
    in_item_t it;
    it = '0;
    it.kind = KindTrace;
    it.tan_h = 16'(th);
    it.tan_v = 16'(tv);
    return it;
  endfunction

  function automatic in_item_t rand_beat();
    in_item_t it;
    it = '0;
    it.kind = ($urandom_range(99) < 40) ? KindLoad : KindTrace;
    it.box_index = 4'($urandom);
    it.box_enable = ($urandom_range(9) != 0);
    if ($urandom_range(99) < 20) begin
      it.center_x = 24'($urandom); it.center_y = 24'($urandom); it.center_z = 24'($urandom);
      it.extent_x = 23'($urandom); it.extent_y = 23'($urandom); it.extent_z = 23'($urandom);
      it.tan_h = 16'($urandom); it.tan_v = 16'($urandom);
    end else begin
      // boxes scattered around the usual line of sight
      it.center_x = 24'(int'($urandom_range(45 * U)) - 20 * U);
      it.center_y = 24'(int'($urandom_range(12 * U)) - 6 * U);
      it.center_z = 24'(int'($urandom_range(12 * U)) - 6 * U);
      it.extent_x = 23'($urandom_range(6 * U));
      it.extent_y = 23'($urandom_range(6 * U));
      it.extent_z = 23'($urandom_range(6 * U));
      it.tan_h = 16'(int'($urandom_range(12000)) - 6000);
      it.tan_v = 16'(int'($urandom_range(12000)) - 6000);
    end
    return it;
  endfunction

  function automatic void queue_beat(in_item_t it);
    item_q.insert(item_q.size(), it);
  endfunction

  // driver: a beat moves when start is high and busy is low
  always @(posedge clk_i) begin
    if (start && !busy) begin
      depth_q.insert(depth_q.size(), march(item_i));
      if (item_i.kind == KindLoad) n_loads++;
      else n_traces++;
    end
    if (!start || !busy) begin
      if (item_q.size() > 0 && $urandom_range(99) >= send_idle) begin
        item_i <= item_q.pop_front();
        start <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    out_item_t want;
    if (result_valid_o) begin
      n_results++;
      if (depth_q.size() == 0) begin
        $display("%0t: unexpected result hit=%0b depth=%0d load_done=%0b", $time,
                 result_o.hit, result_o.depth, result_o.load_done);
        errors++;
      end else begin
        want = depth_q.pop_front();
        if (result_o.hit) n_hits++;
        if (result_o.hit !== want.hit) begin
          $display("%0t: hit expected %0b actual %0b", $time, want.hit, result_o.hit);
          errors++;
        end
        if (result_o.depth !== want.depth) begin
          $display("%0t: depth expected %0d actual %0d", $time, want.depth, result_o.depth);
          errors++;
        end
        if (result_o.load_done !== want.load_done) begin
          $display("%0t: load_done expected %0b actual %0b", $time, want.load_done,
                   result_o.load_done);
          errors++;
        end
      end
    end
  end

  // watchdog on cycles without any accepted beat, result or register write
  always @(posedge clk_i) begin
    if ((start && !busy) || result_valid_o || (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WatchdogLimit) begin
      $display("%0t: watchdog expired", $time);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic set_reg(logic [2:0] idx, int value);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= value[23:0];
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      RegCamX:   cam_x = longint'($signed(value[23:0]));
      RegCamY:   cam_y = longint'($signed(value[23:0]));
      RegCamZ:   cam_z = longint'($signed(value[23:0]));
      RegStep:   step_len = value[15:0];
      RegMaxDst: max_dist = value[22:0];
      default: ;
    endcase
  endtask

  task automatic set_scene(int cx, int cy, int cz, int stp, int maxd);
    set_reg(RegCamX, cx);
    set_reg(RegCamY, cy);
    set_reg(RegCamZ, cz);
    set_reg(RegStep, stp);
    set_reg(RegMaxDst, maxd);
  endtask

  // queue random beats, then hold off until every result is back
  task automatic run_phase(int idle, int n_rand);
    send_idle = idle;
    repeat (n_rand) queue_beat(rand_beat());
    do @(posedge clk_i); while (item_q.size() != 0 || start || depth_q.size() != 0);
    repeat (20) @(posedge clk_i);
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // reset scene: empty table, then boxes on and off the axis
    queue_beat(ray_beat(0, 0));
    queue_beat(box_beat(0, 1'b1, 10 * U, 0, 0, 2 * U, 2 * U, 2 * U));
    queue_beat(ray_beat(0, 0));
    queue_beat(box_beat(15, 1'b1, 8388607, 8388607, 8388607, 8388607, 8388607, 8388607));
    queue_beat(box_beat(7, 1'b1, -8388608, -8388608, -8388608, 0, 0, 0));
    queue_beat(ray_beat(32767, -32768));
    queue_beat(ray_beat(-32768, 32767));
    queue_beat(box_beat(0, 1'b0, 0, 0, 0, 0, 0, 0));
    queue_beat(ray_beat(0, 0));
    queue_beat(box_beat(3, 1'b1, 25 * U, 0, 0, U, U, U));
    queue_beat(ray_beat(1000, -1000));
    run_phase(33, 0);

    set_scene(30 * U, U, -U, 65535, 8388607);
    run_phase(33, 20);

    // unit step, longest range: the step bound ends the march
    set_scene(25 * U, 0, 0, 1, 8388607);
    run_phase(88, 8);

    // zero step and zero range from a corner of space
    set_scene(-8388608, 8388607, 0, 0, 0);
    queue_beat(box_beat(5, 1'b1, -8388608, 8388607, 0, 2 * U, 2 * U, 2 * U));
    queue_beat(ray_beat(0, 0));
    run_phase(88, 10);

    set_scene(20 * U, 0, 0, 3000, 1500000);
    run_phase(0, 30);

    set_scene(1638400, 0, 0, 655, 3276800);
    run_phase(0, 25);

    $display("Covered %0d box loads and %0d traces (%0d hits) over six camera settings;",
             n_loads, n_traces, n_hits);
    $display("%0d results checked, %0d mismatches.", n_results, errors);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
